// ===== rtl/core/local_entropy_filter_5x5_unit_assert.svh =====
// Assertion macros for the checker of this block.
// Both expect a signal named clk, LEF5_ASSERT_RUN also rst_n, in the scope of use.
`ifndef LOCAL_ENTROPY_FILTER_5X5_UNIT_ASSERT_SVH
`define LOCAL_ENTROPY_FILTER_5X5_UNIT_ASSERT_SVH

// Check also while reset is asserted.
`define LEF5_ASSERT_ALWAYS(label, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("lef5 check failed");

// Check only outside reset.
`define LEF5_ASSERT_RUN(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lef5 check failed");

`endif

// ===== rtl/core/lef5_pkg.sv =====
package lef5_pkg;

  localparam int MaxWidth  = 4096;
  localparam int ColAw     = 12;
  localparam int LvlW      = 4;
  localparam int Span      = 5;
  localparam int ColW      = LvlW * Span;
  localparam int StoreW    = LvlW * (Span - 1);
  localparam int NumLevels = 16;
  localparam int TabN      = 32;

  localparam logic [12:0] WidthRst  = 13'd4096;
  localparam logic [15:0] HeightRst = 16'd1;

  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  typedef logic [34:0] lg_tab_t [0:TabN-1];
  typedef logic [39:0] pl_tab_t [0:TabN-1];

  typedef struct packed {
    logic [Span-1:0][ColW-1:0] win;
    logic [Span-1:0]           colv;
    logic [Span-1:0]           rowv;
  } ent_job_t;

  // Truncating Q32 log2 by repeated squaring of the normalized mantissa.
  function automatic logic [34:0] log2_q32(input int unsigned v);
    int unsigned ip;
    logic [63:0] mant;
    logic [31:0] frac;
    ip = 0;
    frac = '0;
    while ((v >> (ip + 1)) != 0) ip++;
    mant = 64'(v) << (31 - ip);
    for (int b = 31; b >= 0; b--) begin
      mant = (mant * mant) >> 31;
      if (mant >= 64'h1_0000_0000) begin
        mant = mant >> 1;
        frac[b] = 1'b1;
      end
    end
    return {ip[2:0], frac};
  endfunction

  function automatic lg_tab_t make_lg();
    lg_tab_t t;
    for (int c = 0; c < TabN; c++) begin
      t[c] = (c == 0 || c > Span * Span) ? 35'd0 : log2_q32(c);
    end
    return t;
  endfunction

  function automatic pl_tab_t make_pl();
    pl_tab_t t;
    logic [34:0] l;
    for (int c = 0; c < TabN; c++) begin
      l = (c == 0 || c > Span * Span) ? 35'd0 : log2_q32(c);
      t[c] = 40'(l) * 40'(c);
    end
    return t;
  endfunction

  localparam lg_tab_t LgTab = make_lg();
  localparam pl_tab_t PlTab = make_pl();

endpackage

// ===== rtl/core/lef5_if.sv =====
interface lef5_in_if;
  import lef5_pkg::*;
  logic            valid;
  logic            ready;
  logic [LvlW-1:0] pixel_level;
  logic            flush;
  modport source(output valid, pixel_level, flush, input ready);
  modport sink(input valid, pixel_level, flush, output ready);
endinterface

interface lef5_out_if;
  logic        valid;
  logic        ready;
  logic [18:0] entropy_q16;
  logic        last_of_image;
  modport source(output valid, entropy_q16, last_of_image, input ready);
  modport sink(input valid, entropy_q16, last_of_image, output ready);
endinterface

// ===== rtl/core/lef5_colstore.sv =====
module lef5_colstore (
  input  logic                        clk,
  input  logic                        rd_en,
  input  logic [lef5_pkg::ColAw-1:0]  rd_addr,
  output logic [lef5_pkg::StoreW-1:0] rd_data_r,
  input  logic                        wr_en,
  input  logic [lef5_pkg::ColAw-1:0]  wr_addr,
  input  logic [lef5_pkg::StoreW-1:0] wr_data
);
  import lef5_pkg::*;

  // Four older rows of one column per entry, newest in the low nibble.
  logic [StoreW-1:0] mem_r [0:MaxWidth-1];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end
endmodule

// ===== rtl/core/lef5_entropy.sv =====
module lef5_entropy (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  lef5_pkg::ent_job_t job,
  input  logic              ack,
  output logic              done,
  output logic [18:0]       ent_q16
);
  import lef5_pkg::*;

  localparam logic [2:0] E_IDLE = 3'd0;
  localparam logic [2:0] E_HIST = 3'd1;
  localparam logic [2:0] E_SUM  = 3'd2;
  localparam logic [2:0] E_DIV  = 3'd3;
  localparam logic [2:0] E_RND  = 3'd4;
  localparam logic [2:0] E_FIN  = 3'd5;

  logic [2:0]  st_r, st_nxt;
  logic [5:0]  step_r;
  ent_job_t    job_r;
  logic [4:0]  hist_r [0:NumLevels-1];
  logic [4:0]  cells_r;
  logic [39:0] acc_r;
  logic [4:0]  rem_r;
  logic [18:0] res_r;

  logic [2:0]  inc    [0:NumLevels-1];
  logic [2:0]  ncell;
  logic [ColW-1:0] cur_col;
  logic [5:0]  rem_t;
  logic        qbit;
  logic [34:0] lgv;
  logic [34:0] ent;
  logic [19:0] rnd;

  // Count the valid cells of one window column into the bins.
  always_comb begin
    cur_col = job_r.win[step_r[2:0]];
    ncell = '0;
    for (int b = 0; b < NumLevels; b++) begin
      inc[b] = '0;
    end
    for (int j = 0; j < Span; j++) begin
      if (job_r.rowv[j] && job_r.colv[step_r[2:0]]) begin
        ncell = ncell + 3'd1;
        inc[cur_col[j*LvlW +: LvlW]] = inc[cur_col[j*LvlW +: LvlW]] + 3'd1;
      end
    end
  end

  always_comb begin
    rem_t = {rem_r, acc_r[39]};
    qbit  = (rem_t >= {1'b0, cells_r});
    lgv   = LgTab[cells_r];
    ent   = (acc_r >= {5'd0, lgv}) ? 35'd0 : (lgv - acc_r[34:0]);
    rnd   = 20'((ent + 35'd32768) >> 16);
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      E_IDLE: if (start) st_nxt = E_HIST;
      E_HIST: if (step_r == 6'(Span - 1)) st_nxt = E_SUM;
      E_SUM:  if (step_r == 6'(NumLevels - 1)) st_nxt = E_DIV;
      E_DIV:  if (step_r == 6'd39) st_nxt = E_RND;
      E_RND:  st_nxt = E_FIN;
      E_FIN:  if (ack) st_nxt = E_IDLE;
      default: st_nxt = E_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= E_IDLE;
    end else begin
      st_r <= st_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (st_r)
      E_IDLE: begin
        job_r   <= job;
        step_r  <= '0;
        cells_r <= '0;
        acc_r   <= '0;
        for (int b = 0; b < NumLevels; b++) begin
          hist_r[b] <= '0;
        end
      end
      E_HIST: begin
        for (int b = 0; b < NumLevels; b++) begin
          hist_r[b] <= hist_r[b] + 5'(inc[b]);
        end
        cells_r <= cells_r + 5'(ncell);
        step_r  <= (step_r == 6'(Span - 1)) ? 6'd0 : step_r + 6'd1;
      end
      E_SUM: begin
        acc_r  <= acc_r + PlTab[hist_r[step_r[3:0]]];
        step_r <= (step_r == 6'(NumLevels - 1)) ? 6'd0 : step_r + 6'd1;
        rem_r  <= '0;
      end
      E_DIV: begin
        // Restoring division, one quotient bit a cycle into acc_r.
        rem_r  <= qbit ? 5'(rem_t - {1'b0, cells_r}) : rem_t[4:0];
        acc_r  <= {acc_r[38:0], qbit};
        step_r <= step_r + 6'd1;
      end
      E_RND: begin
        res_r <= rnd[19] ? 19'h7FFFF : rnd[18:0];
      end
      default: begin
      end
    endcase
  end

  assign done    = (st_r == E_FIN);
  assign ent_q16 = res_r;
endmodule

// ===== rtl/core/local_entropy_filter_5x5_unit.sv =====
// A pixel's result leaves with item k+2*width+2, passing through the column,
// histogram, sum, divide and round steps and the output register after that item.
// No new item is taken until the column store's read-then-write is done and,
// for an item with a result, the shared iterative divider has handed it out.
// Reset (rst_n, synchronous, active low) clears counters, window and handshakes;
// width resets to 4096, height to 1. The column store needs no clearing.
module local_entropy_filter_5x5_unit (
  input  logic        clk,
  input  logic        rst_n,
  lef5_in_if.sink     in_ch,
  lef5_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import lef5_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_COL  = 2'd1;
  localparam logic [1:0] ST_WAIT = 2'd2;

  logic [1:0]  st_r, st_nxt;
  logic [12:0] width_r;
  logic [15:0] height_r;
  logic [ColAw-1:0] ic_r;
  logic [16:0] ir_r;
  logic [ColAw-1:0] oc_r;
  logic [15:0] or_r;
  logic [13:0] pos_r;
  logic [LvlW-1:0] pix_r;
  logic [ColW-1:0] win_r [0:Span-1];
  logic        out_valid_r;
  logic [18:0] out_ent_r;
  logic        out_last_r;
  logic        last_r;

  logic [12:0] eff_w;
  logic [15:0] eff_h;
  logic [13:0] lag;
  logic        accept, drop, in_img, cfg_we, produce;
  logic [StoreW-1:0] rd_data;
  logic [ColW-1:0]   new_col;
  ent_job_t    job;
  logic        ent_done, ent_ack;
  logic [18:0] ent_q16;
  logic        out_load;
  logic [12:0] ic_inc, oc_inc;
  logic [15:0] or_inc;

  // Out-of-range geometry folds onto the nearest legal value.
  assign eff_w  = (width_r == 13'd0) ? 13'd1 : ((width_r > WidthRst) ? WidthRst : width_r);
  assign eff_h  = (height_r == 16'd0) ? 16'd1 : height_r;
  assign lag    = {eff_w, 1'b0} + 14'd2;
  assign in_img = (ir_r < {1'b0, eff_h});

  assign in_ch.ready = (st_r == ST_IDLE);
  assign accept = in_ch.valid && in_ch.ready;
  // Flush inside the image advances nothing; after the image, flush and pixel act alike.
  assign drop   = in_ch.flush && in_img;
  assign cfg_we = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_HEIGHT) ? {16'd0, height_r} : {19'd0, width_r};

  // Column store: read on accept, write back the shifted column next cycle.
  lef5_colstore u_colstore (
    .clk       (clk),
    .rd_en     (accept && !drop),
    .rd_addr   (ic_r),
    .rd_data_r (rd_data),
    .wr_en     (st_r == ST_COL),
    .wr_addr   (ic_r),
    .wr_data   ({rd_data[StoreW-LvlW-1:0], pix_r})
  );

  // Window column, oldest row in the low nibble, current pixel on top.
  assign new_col = {pix_r, rd_data[3:0], rd_data[7:4], rd_data[11:8], rd_data[15:12]};
  assign produce = (pos_r >= lag) && (or_r < eff_h);

  always_comb begin
    for (int i = 0; i < Span - 1; i++) begin
      job.win[i] = win_r[i+1];
    end
    job.win[Span-1] = new_col;
    job.colv[0] = (oc_r >= 12'd2);
    job.colv[1] = (oc_r >= 12'd1);
    job.colv[2] = 1'b1;
    job.colv[3] = ({1'b0, oc_r} + 13'd1 < eff_w);
    job.colv[4] = ({1'b0, oc_r} + 13'd2 < eff_w);
    job.rowv[0] = (or_r >= 16'd2);
    job.rowv[1] = (or_r >= 16'd1);
    job.rowv[2] = 1'b1;
    job.rowv[3] = ({1'b0, or_r} + 17'd1 < {1'b0, eff_h});
    job.rowv[4] = ({1'b0, or_r} + 17'd2 < {1'b0, eff_h});
  end

  lef5_entropy u_entropy (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   ((st_r == ST_COL) && produce),
    .job     (job),
    .ack     (ent_ack),
    .done    (ent_done),
    .ent_q16 (ent_q16)
  );

  // Hold the result until the output register is free.
  assign out_load = (st_r == ST_WAIT) && ent_done && (!out_valid_r || out_ch.ready);
  assign ent_ack  = out_load;

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      ST_IDLE: if (accept && !drop) st_nxt = ST_COL;
      ST_COL:  st_nxt = produce ? ST_WAIT : ST_IDLE;
      ST_WAIT: if (out_load) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  assign ic_inc = {1'b0, ic_r} + 13'd1;
  assign oc_inc = {1'b0, oc_r} + 13'd1;
  assign or_inc = or_r + 16'd1;

  always_ff @(posedge clk) begin
    if (accept && !drop) begin
      pix_r <= in_ch.pixel_level;
    end
    if ((st_r == ST_COL) && produce) begin
      last_r <= (or_r == eff_h - 16'd1) && ({1'b0, oc_r} == eff_w - 13'd1);
    end
    if (out_load) begin
      out_ent_r  <= ent_q16;
      out_last_r <= last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      width_r     <= WidthRst;
      height_r    <= HeightRst;
      ic_r        <= '0;
      ir_r        <= '0;
      oc_r        <= '0;
      or_r        <= '0;
      pos_r       <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < Span; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      st_r <= st_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        // A register write starts a new image.
        if (paddr[2] == REG_HEIGHT) begin
          height_r <= pwdata[15:0];
        end else begin
          width_r <= pwdata[12:0];
        end
        ic_r  <= '0;
        ir_r  <= '0;
        oc_r  <= '0;
        or_r  <= '0;
        pos_r <= '0;
      end else if (st_r == ST_COL) begin
        for (int i = 0; i < Span - 1; i++) begin
          win_r[i] <= win_r[i+1];
        end
        win_r[Span-1] <= new_col;
        if (produce && (oc_inc >= eff_w) && (or_inc >= eff_h)) begin
          // Final result of the image: clear all position counters.
          ic_r  <= '0;
          ir_r  <= '0;
          oc_r  <= '0;
          or_r  <= '0;
          pos_r <= '0;
        end else begin
          if (ic_inc >= eff_w) begin
            ic_r <= '0;
            ir_r <= ir_r + 17'd1;
          end else begin
            ic_r <= ic_inc[ColAw-1:0];
          end
          if (pos_r < lag) begin
            pos_r <= pos_r + 14'd1;
          end
          if (produce) begin
            if (oc_inc >= eff_w) begin
              oc_r <= '0;
              or_r <= or_inc;
            end else begin
              oc_r <= oc_inc[ColAw-1:0];
            end
          end
        end
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.entropy_q16   = out_ent_r;
  assign out_ch.last_of_image = out_last_r;
endmodule

// ===== rtl/core/lef5_checker.sv =====
`include "local_entropy_filter_5x5_unit_assert.svh"

module lef5_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        in_flush,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_last,
  input logic [18:0] out_ent
);
  `LEF5_ASSERT_ALWAYS(a_rst_out_idle, !rst_n, !out_valid)
  `LEF5_ASSERT_RUN(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_ent))
  `LEF5_ASSERT_RUN(a_pixel_busy, in_valid && in_ready && !in_flush, !in_ready)
  `LEF5_ASSERT_RUN(a_last_hold, out_valid && !out_ready, $stable(out_last))
endmodule

bind local_entropy_filter_5x5_unit lef5_checker u_lef5_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_flush  (in_ch.flush),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_last  (out_ch.last_of_image),
  .out_ent   (out_ch.entropy_q16)
);

// ===== dv/local_entropy_filter_5x5_unit_checker.sv =====
`timescale 1ns / 1ps

module local_entropy_filter_5x5_unit_checker (
  input  logic        clk,
  input  logic        rst_n,
  lef5_in_if          in_mon,
  lef5_out_if         out_mon,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending,
  output int          results_seen
);
  import lef5_pkg::*;

  localparam int Rad  = 2;
  localparam int Ring = 3 * Rad + 1;
  localparam int Cells = (2 * Rad + 1) * (2 * Rad + 1);

  typedef struct packed {
    logic [18:0] entropy_q16;
    logic        last_of_image;
  } entropy_res_t;

  entropy_res_t entropy_due[$];

  logic [LvlW-1:0] pixel_rows [0:Ring-1][0:MaxWidth-1];
  logic [12:0] width_reg;
  logic [15:0] height_reg;
  int unsigned in_col, in_row, out_col, out_row;
  longint unsigned log_q32 [0:Cells];
  longint unsigned clogc_q32 [0:Cells];

  // Q32 log2: integer part from the leading one, fraction by squaring.
  function automatic longint unsigned log2_fix(int unsigned v);
    int unsigned ip;
    longint unsigned m;
    longint unsigned fr;
    ip = 0;
    fr = 0;
    while ((v >> (ip + 1)) != 0) ip++;
    m = longint'(v) << (31 - ip);
    for (int b = 31; b >= 0; b--) begin
      m = (m * m) >> 31;
      if (m >= 64'h1_0000_0000) begin
        m = m >> 1;
        fr = fr | (64'd1 << b);
      end
    end
    return (longint'(ip) << 32) | fr;
  endfunction

  function automatic logic [18:0] predict_entropy(int unsigned row, int unsigned col,
                                                  int unsigned wd, int unsigned ht);
    int unsigned hist [0:NumLevels-1];
    int unsigned n;
    longint rr, cc;
    longint unsigned acc, avg, ent;
    n = 0;
    acc = 0;
    for (int b = 0; b < NumLevels; b++) hist[b] = 0;
    for (int dr = -Rad; dr <= Rad; dr++) begin
      rr = longint'(row) + dr;
      if (rr < 0 || rr >= ht) continue;
      for (int dc = -Rad; dc <= Rad; dc++) begin
        cc = longint'(col) + dc;
        if (cc < 0 || cc >= wd) continue;
        hist[pixel_rows[rr % Ring][cc]]++;
        n++;
      end
    end
    if (n == 0) return '0;
    for (int b = 0; b < NumLevels; b++) acc += clogc_q32[hist[b]];
    avg = acc / n;
    ent = (avg >= log_q32[n]) ? 0 : log_q32[n] - avg;
    ent = (ent + 32768) >> 16;
    if (ent > 64'h7FFFF) ent = 64'h7FFFF;
    return ent[18:0];
  endfunction

  function automatic void clear_pos();
    in_col = 0; in_row = 0; out_col = 0; out_row = 0;
  endfunction

  task automatic take_pixel(logic [3:0] lvl, logic fl);
    int unsigned wd, ht;
    longint unsigned pos, total, lag;
    entropy_res_t r;
    wd = (width_reg == 0) ? 1 : (width_reg > MaxWidth ? MaxWidth : width_reg);
    ht = (height_reg == 0) ? 1 : height_reg;
    pos = longint'(in_row) * wd + in_col;
    total = longint'(ht) * wd;
    lag = 2 * wd + 2;
    if (pos < total) begin
      // flush inside the image is dropped without advancing
      if (fl) return;
      pixel_rows[in_row % Ring][in_col] = lvl;
    end
    if (pos >= lag && out_row < ht) begin
      r.entropy_q16 = predict_entropy(out_row, out_col, wd, ht);
      r.last_of_image = (out_row == ht - 1 && out_col == wd - 1);
      entropy_due.push_back(r);
      if (++out_col >= wd) begin
        out_col = 0;
        out_row++;
      end
    end
    if (++in_col >= wd) begin
      in_col = 0;
      in_row++;
    end
    if (out_row >= ht) clear_pos();
  endtask

  initial begin
    fail_count = 0;
    results_seen = 0;
    width_reg = WidthRst;
    height_reg = HeightRst;
    clear_pos();
    for (int r = 0; r < Ring; r++)
      for (int c = 0; c < MaxWidth; c++) pixel_rows[r][c] = '0;
    log_q32[0] = 0;
    clogc_q32[0] = 0;
    for (int c = 1; c <= Cells; c++) begin
      log_q32[c] = log2_fix(c);
      clogc_q32[c] = log_q32[c] * c;
    end
  end

  assign pending = entropy_due.size();

  always @(posedge clk) begin
    entropy_res_t exp_r;
    if (!rst_n) begin
      width_reg = WidthRst;
      height_reg = HeightRst;
      clear_pos();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_WIDTH) width_reg = pwdata[12:0];
        else height_reg = pwdata[15:0];
        clear_pos();
      end
      if (out_mon.valid && out_mon.ready) begin
        results_seen++;
        if (entropy_due.size() == 0) begin
          $error("unexpected result: entropy_q16 %0d", out_mon.entropy_q16);
          fail_count++;
        end else begin
          exp_r = entropy_due.pop_front();
          if (out_mon.entropy_q16 !== exp_r.entropy_q16) begin
            $error("entropy_q16: expected %0d, got %0d", exp_r.entropy_q16,
                   out_mon.entropy_q16);
            fail_count++;
          end
          if (out_mon.last_of_image !== exp_r.last_of_image) begin
            $error("last_of_image: expected %0d, got %0d", exp_r.last_of_image,
                   out_mon.last_of_image);
            fail_count++;
          end
        end
      end
      if (in_mon.valid && in_mon.ready) take_pixel(in_mon.pixel_level, in_mon.flush);
    end
  end

endmodule

// ===== dv/local_entropy_filter_5x5_unit_tb.sv =====
`timescale 1ns / 1ps

module local_entropy_filter_5x5_unit_tb;
  import lef5_pkg::*;

  localparam int CycleLimit = 3000000;
  localparam int SettleCycles = 200;

  logic        clk;
  logic        rst_n;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count, pending, results_seen;
  int          cycles;
  int          items_sent;
  int          images_run;
  bit          quiet;      // no idling on either side while set
  bit          hold_go;    // ask the receiver for one long hold-off

  lef5_in_if  in_ch();
  lef5_out_if out_ch();

  local_entropy_filter_5x5_unit uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  local_entropy_filter_5x5_unit_checker chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
    .paddr(paddr), .pwdata(pwdata), .fail_count(fail_count),
    .pending(pending), .results_seen(results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Abort a hung run.
  initial begin
    cycles = 0;
    forever begin
      @(posedge clk);
      cycles++;
      if (cycles > CycleLimit) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // Receiver: random stalls, mostly short; one long hold-off on request.
  initial begin
    int stall_left;
    int r;
    stall_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        stall_left = 4000;
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else if (quiet) begin
        out_ch.ready <= 1'b1;
      end else begin
        r = $urandom_range(99);
        if (r < 10) stall_left = $urandom_range(1, 4);
        else if (r < 12) stall_left = $urandom_range(20, 90);
        out_ch.ready <= (stall_left == 0);
      end
    end
  end

  // Offer one item, idling first at random, and hold it until taken.
  task automatic send_item(logic [3:0] lvl, logic fl);
    int r, gap;
    r = $urandom_range(99);
    gap = 0;
    if (!quiet) begin
      if (r < 25) gap = $urandom_range(1, 3);
      else if (r < 29) gap = $urandom_range(10, 40);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.pixel_level <= lvl;
    in_ch.flush <= fl;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    items_sent++;
  endtask

  task automatic reg_write(logic [2:0] addr, logic [31:0] data);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // Drain all due results, then let trailing work finish.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  // Program the size, stream one image and its trailing items.
  // n_pix below the full size cuts the image short (no trailing items).
  // lvl_mode: 0 random, 1 alternate extremes, 2 constant level.
  task automatic run_image(logic [12:0] w_reg, logic [15:0] h_reg, int n_pix,
                           int noise_pct, int lvl_mode);
    int w, h, full, trail;
    logic [3:0] lvl;
    w = (w_reg == 0) ? 1 : (w_reg > MaxWidth ? MaxWidth : w_reg);
    h = (h_reg == 0) ? 1 : h_reg;
    full = w * h;
    reg_write(3'(REG_WIDTH) << 2, 32'(w_reg) | 32'hFFFF_E000 & 32'($urandom));
    reg_write(3'(REG_HEIGHT) << 2, 32'(h_reg) | 32'hFFFF_0000 & 32'($urandom));
    if (n_pix > full || n_pix < 0) n_pix = full;
    for (int i = 0; i < n_pix; i++) begin
      // stray flush inside the image must be dropped
      if ($urandom_range(99) < noise_pct) send_item(4'($urandom), 1'b1);
      case (lvl_mode)
        1: lvl = (i % 2) ? 4'hF : 4'h0;
        2: lvl = 4'h7;
        default: lvl = 4'($urandom);
      endcase
      send_item(lvl, 1'b0);
    end
    if (n_pix == full) begin
      trail = 2 * w + 2;
      // after the image a pixel counts as a flush
      for (int i = 0; i < trail; i++) send_item(4'($urandom), 1'($urandom));
    end
    images_run++;
    drain();
  endtask

  initial begin
    int w, h;
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_ch.valid = 1'b0; in_ch.pixel_level = '0; in_ch.flush = 1'b0;
    items_sent = 0;
    images_run = 0;
    quiet = 1'b0;
    hold_go = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: zero sizes fold to one, extreme levels, constant image,
    // an image cut short by a register write at the largest height.
    run_image(13'd0, 16'd0, -1, 0, 1);
    run_image(13'd3, 16'd2, -1, 20, 1);
    run_image(13'd2, 16'd1, -1, 0, 2);
    run_image(13'd1, 16'hFFFF, 6, 0, 0);

    // Random well-formed images, one long receiver hold-off early on.
    hold_go = 1'b1;
    run_image(13'd6, 16'd5, -1, 5, 0);
    while (items_sent < 440) begin
      quiet = ($urandom_range(5) == 0);
      w = $urandom_range(1, 8);
      h = $urandom_range(1, 6);
      run_image(13'(w), 16'(h), -1, 5, 0);
    end
    quiet = 1'b0;

    // Widest setting: width beyond the maximum folds to the maximum;
    // cut short after a few pixels to keep the run small.
    run_image(13'h1FFF, 16'd1, 8, 1, 0);

    $display("Ran %0d images over %0d items, %0d results checked,", images_run,
             items_sent, results_seen);
    $display("sizes from 1x1 up to 8x6 with random stalls, plus a short widest row.");
    if (fail_count == 0 && pending == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
